// ===== rtl/cmst_pkg.sv =====
package cmst_pkg;

  localparam int          SLOTS_DEF   = 16;
  localparam int          CFG_W       = 5;
  localparam logic [4:0]  SLOTS_RESET = 5'd16;
  localparam logic [7:0]  EMPTY_ID    = 8'hFF;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_QUERY  = 3'd0,
    REQ_SET    = 3'd1,
    REQ_INC    = 3'd2,
    REQ_DEC    = 3'd3,
    REQ_RENAME = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_code_t;

  // Table update broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_DEL    = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_RENAME = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] object_id;
    logic [7:0] second_object;
    logic [7:0] new_count;
  } req_t;

  typedef struct packed {
    logic [7:0] count;
    logic       present;
    logic       done_res;
  } rsp_t;

  // Handed from cell to cell along the row
  typedef struct packed {
    logic       hit_seen;
    logic       empty_seen;
    logic       obj2_seen;
    logic [7:0] count;
  } link_t;

  // Broadcast from the controller to all cells
  typedef struct packed {
    logic       look;
    op_t        op;
    logic [7:0] obj;
    logic [7:0] obj2;
    logic [7:0] newc;
  } cell_ctl_t;

endpackage

// ===== rtl/cmst_cell.sv =====
module cmst_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cmst_pkg::cell_ctl_t ctl,
  input  logic [4:0]          n,
  input  cmst_pkg::link_t     link_in,
  output cmst_pkg::link_t     link_out
);
  import cmst_pkg::*;

  localparam bit IDX_BIG = (IDX > 31);

  logic [7:0] id;
  logic [7:0] cnt;
  logic       match_r;
  logic       first_hit_r;
  logic       first_empty_r;

  logic used;
  logic match;
  logic is_empty;

  assign used     = !IDX_BIG && (5'(IDX) < n);
  assign match    = used && (id == ctl.obj);
  assign is_empty = used && (id == EMPTY_ID);

  // first match upstream wins the count
  always_comb begin
    link_out.hit_seen   = link_in.hit_seen | match;
    link_out.empty_seen = link_in.empty_seen | is_empty;
    link_out.obj2_seen  = link_in.obj2_seen | (used && (id == ctl.obj2));
    link_out.count      = (match && !link_in.hit_seen) ? cnt : link_in.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id            <= EMPTY_ID;
      cnt           <= 8'd0;
      match_r       <= 1'b0;
      first_hit_r   <= 1'b0;
      first_empty_r <= 1'b0;
    end else begin
      if (ctl.look) begin
        match_r       <= match;
        first_hit_r   <= match && !link_in.hit_seen;
        first_empty_r <= is_empty && !link_in.empty_seen;
      end
      case (ctl.op)
        OP_DEL: begin
          if (match_r) begin
            id  <= EMPTY_ID;
            cnt <= 8'd0;
          end
        end
        OP_WRITE: begin
          if (first_hit_r) cnt <= ctl.newc;
        end
        OP_INSERT: begin
          if (first_empty_r) begin
            id  <= ctl.obj;
            cnt <= ctl.newc;
          end
        end
        OP_RENAME: begin
          if (first_hit_r) begin
            id <= ctl.obj2;
            if (ctl.obj2 == EMPTY_ID) cnt <= 8'd0;
          end
        end
        OP_CLEAR: begin
          id  <= EMPTY_ID;
          cnt <= 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/counted_multiset_table.sv =====
// Each request runs a lookup on the cell row, then an update that writes the
//   cells and loads the result register when it commits.
// A waiting result holds the update cycle, and no new request is taken until
//   that update commits.
// Reset (synchronous, rst high): all slots empty with count 0,
//   slots_in_use back to 16, no result pending.
module counted_multiset_table #(
  parameter int SLOTS = cmst_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cmst_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  cmst_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output cmst_pkg::rsp_t                   rsp
);
  import cmst_pkg::*;

  // Largest usable slot count: SLOTS, capped at 31 by the 5-bit register
  localparam int         NMAX  = (SLOTS < 31) ? SLOTS : 31;
  localparam logic [4:0] NMAX5 = 5'(NMAX);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t     state;
  state_t     state_next;

  logic [4:0] slots_in_use;
  logic [4:0] n;

  req_t       req_r;
  logic [7:0] count_r;
  logic       hit_any;
  logic       empty_any;
  logic       obj2_any;

  link_t      links [SLOTS+1];
  cell_ctl_t  ctl;

  logic       obj_ok;
  logic       upd_go;
  logic       is_cnt;
  logic [7:0] newc;
  op_t        op_sel;
  logic       done_sel;
  logic       present_sel;

  // Configuration: hold the raw value, clamp on use
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (cfg_we) begin
      slots_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (slots_in_use == 5'd0) begin
      n = 5'd1;
    end else if (slots_in_use > NMAX5) begin
      n = NMAX5;
    end else begin
      n = slots_in_use;
    end
  end

  // Row of cells; the search results ripple from slot 0 upward
  assign links[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    cmst_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .n        (n),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign obj_ok = (req_r.object_id != EMPTY_ID);
  // Update may commit unless a finished result still sits unclaimed
  assign upd_go = !rsp_valid || rsp_ready;

  // Take a new request when idle, or in the cycle the current update commits
  assign req_ready = (state == S_IDLE) || ((state == S_UPD) && upd_go);

  // New count for set, increment (saturate) and decrement (floor at zero)
  always_comb begin
    case (req_r.req_type)
      REQ_SET: newc = req_r.new_count;
      REQ_INC: newc = (count_r == 8'hFF) ? 8'hFF : count_r + 8'd1;
      REQ_DEC: newc = (count_r == 8'd0) ? 8'd0 : count_r - 8'd1;
      default: newc = count_r;
    endcase
  end

  assign is_cnt = obj_ok && (req_r.req_type inside {REQ_SET, REQ_INC, REQ_DEC});

  // Pick the table update and the done flag
  always_comb begin
    op_sel   = OP_NONE;
    done_sel = 1'b0;
    if (is_cnt) begin
      if (newc != count_r) begin
        if (newc == 8'd0) begin
          // count dropped to zero: free every slot of the object
          op_sel   = OP_DEL;
          done_sel = 1'b1;
        end else if (hit_any) begin
          op_sel   = OP_WRITE;
          done_sel = 1'b1;
        end else if (empty_any) begin
          op_sel   = OP_INSERT;
          done_sel = 1'b1;
        end
      end
    end else if ((req_r.req_type == REQ_RENAME) && obj_ok) begin
      if (hit_any) begin
        op_sel   = OP_RENAME;
        done_sel = 1'b1;
      end
    end else if (req_r.req_type == REQ_CLEAR) begin
      op_sel   = OP_CLEAR;
      done_sel = 1'b1;
    end
  end

  assign present_sel = hit_any || ((req_r.second_object != EMPTY_ID) && obj2_any);

  always_comb begin
    ctl.look = (state == S_LOOK);
    ctl.op   = ((state == S_UPD) && upd_go) ? op_sel : OP_NONE;
    ctl.obj  = req_r.object_id;
    ctl.obj2 = req_r.second_object;
    ctl.newc = newc;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (upd_go) state_next = req_valid ? S_LOOK : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request and the lookup summary
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_r <= req;
    if (state == S_LOOK) begin
      count_r   <= obj_ok ? links[SLOTS].count : 8'd0;
      hit_any   <= obj_ok && links[SLOTS].hit_seen;
      empty_any <= links[SLOTS].empty_seen;
      obj2_any  <= links[SLOTS].obj2_seen;
    end
  end

  // Result register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_UPD) && upd_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_UPD) && upd_go) begin
      rsp.count    <= count_r;
      rsp.present  <= present_sel;
      rsp.done_res <= done_sel;
    end
  end

  a_rsp_from_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_UPD))
    else $error("result appeared without an update cycle");

  a_no_take_in_look: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> !req_ready)
    else $error("request taken during lookup");

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_LOOK))
    else $error("accepted request did not start a lookup");

  a_insert_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_INSERT) |-> (!hit_any && empty_any))
    else $error("insert issued with a hit or a full table");

  a_upd_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UPD) && !upd_go) |=> ((state == S_UPD) && $stable(req_r)))
    else $error("stalled update lost its request");

endmodule
